[sv/sldf_pkg.sv]
package sldf_pkg;

  // Fixed field widths of the byte stream.
  localparam int BYTE_W = 8;
  localparam int POS_W  = 9;

  // Default frame geometry.
  localparam int HEADER_LEN_DEF = 2;
  localparam int IV_LEN_DEF     = 16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] ID_DOUBLE_IV = 8'h01;

  // One emitted frame word with its side information.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  frame_position;
    logic [POS_W-1:0]  padded_length;
    logic              end_of_frame;
  } sldf_result_t;

endpackage

[sv/sldf_parser.sv]
module sldf_parser #(
  parameter int HEADER_LEN = sldf_pkg::HEADER_LEN_DEF,
  parameter int IV_LEN     = sldf_pkg::IV_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [sldf_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          res_valid,
  output sldf_pkg::sldf_result_t        res
);
  import sldf_pkg::*;

  localparam int SYNC_W = $clog2(HEADER_LEN + 1);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_ID   = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam logic [POS_W-1:0] IV_ADD  = POS_W'(IV_LEN);
  localparam logic [POS_W-1:0] HDR_ADD = POS_W'(HEADER_LEN);
  localparam logic [POS_W-1:0] LEN_BIAS = POS_W'(20);

  logic [1:0]        phase, phase_next;
  logic [SYNC_W-1:0] sync_count, sync_count_next;
  logic [POS_W-1:0]  padded_len_reg, padded_len_reg_next;
  logic [POS_W-1:0]  bytes_left, bytes_left_next;
  logic [POS_W-1:0]  position_count, position_count_next;

  logic [SYNC_W-1:0] sync_inc;
  logic [POS_W-1:0]  len_sum;
  logic [POS_W-1:0]  len_padded;
  logic [POS_W-1:0]  frame_count;
  logic              last_byte;

  always_comb begin
    sync_inc    = sync_count + 1'b1;
    // (length + 5) rounded up to sixteen is (length + 20) with the low nibble cleared.
    len_sum     = POS_W'(rx_byte) + LEN_BIAS;
    len_padded  = {len_sum[POS_W-1:4], 4'b0000};
    frame_count = padded_len_reg + IV_ADD + HDR_ADD;
    if (rx_byte == ID_DOUBLE_IV) begin
      frame_count = frame_count + IV_ADD;
    end
    last_byte = (bytes_left <= POS_W'(1));

    phase_next          = phase;
    sync_count_next     = sync_count;
    padded_len_reg_next = padded_len_reg;
    bytes_left_next     = bytes_left;
    position_count_next = position_count;
    res_valid           = 1'b0;
    res.frame_byte      = rx_byte;
    res.frame_position  = position_count;
    res.padded_length   = padded_len_reg;
    res.end_of_frame    = 1'b0;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_BYTE) begin
          if (sync_inc == SYNC_W'(HEADER_LEN)) begin
            sync_count_next = '0;
            phase_next      = PH_LEN;
          end else begin
            sync_count_next = sync_inc;
          end
        end else begin
          sync_count_next = '0;
        end
      end
      PH_LEN: begin
        res_valid           = 1'b1;
        res.frame_position  = '0;
        res.padded_length   = len_padded;
        padded_len_reg_next = len_padded;
        position_count_next = POS_W'(1);
        phase_next          = PH_ID;
      end
      PH_ID: begin
        res_valid           = 1'b1;
        res.frame_position  = POS_W'(1);
        bytes_left_next     = frame_count;
        position_count_next = POS_W'(2);
        phase_next          = PH_DATA;
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.end_of_frame = last_byte;
        if (last_byte) begin
          bytes_left_next     = '0;
          position_count_next = '0;
          sync_count_next     = '0;
          phase_next          = PH_HUNT;
        end else begin
          bytes_left_next     = bytes_left - 1'b1;
          position_count_next = position_count + 1'b1;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      sync_count     <= '0;
      padded_len_reg <= '0;
      bytes_left     <= '0;
      position_count <= '0;
    end else if (step) begin
      phase          <= phase_next;
      sync_count     <= sync_count_next;
      padded_len_reg <= padded_len_reg_next;
      bytes_left     <= bytes_left_next;
      position_count <= position_count_next;
    end
  end

endmodule

[sv/sldf_out_reg.sv]
module sldf_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  sldf_pkg::sldf_result_t        res,
  input  logic                          out_ready,
  output logic                          out_free,
  output logic                          out_valid,
  output sldf_pkg::sldf_result_t        out_res
);
  import sldf_pkg::*;

  // The slot can take a new word when empty or when its word leaves this cycle.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      out_res <= res;
    end
  end

endmodule

[sv/sync_length_frame_deframer_unit.sv]
// A byte accepted at the input is held in the input register; the parser decodes it
// combinationally and, once the output register has room, loads its frame word into the
// output register, which presents it to the consumer.
// Throughput: one byte per cycle unless the consumer stalls; the input register and the
// output register each move whenever the stage behind them is free, so bubbles and stalls
// cost nothing extra. Reset (synchronous, active high) empties both registers and returns
// the parser to sync hunting with all counters cleared.
module sync_length_frame_deframer_unit #(
  parameter int HEADER_LEN = sldf_pkg::HEADER_LEN_DEF,
  parameter int IV_LEN     = sldf_pkg::IV_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sldf_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sldf_pkg::BYTE_W-1:0]   frame_byte,
  output logic [sldf_pkg::POS_W-1:0]    frame_position,
  output logic [sldf_pkg::POS_W-1:0]    padded_length,
  output logic                          end_of_frame
);
  import sldf_pkg::*;

  // Input register: holds one received word until the parser consumes it.
  logic              in_held;
  logic [BYTE_W-1:0] in_byte;

  logic         out_free;
  logic         step;
  logic         res_valid;
  sldf_result_t res;
  sldf_result_t out_res;

  // The held word is parsed once the output register has room for its result.
  // A sync word yields no result but is held to the same rule, which keeps the
  // ready path simple without costing rate.
  assign step     = in_held && out_free;
  assign in_ready = !in_held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  // Frame parser: sync hunt, length, ID and payload phases with their counters.
  sldf_parser #(
    .HEADER_LEN(HEADER_LEN),
    .IV_LEN    (IV_LEN)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register: keeps the finished frame word until the consumer takes it.
  sldf_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .res      (res),
    .out_ready(out_ready),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  assign frame_byte     = out_res.frame_byte;
  assign frame_position = out_res.frame_position;
  assign padded_length  = out_res.padded_length;
  assign end_of_frame   = out_res.end_of_frame;

  // An empty input register must always be able to take a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_held |-> in_ready)
    else $error("input refused while the input register is empty");

  // The padded length is always a multiple of sixteen on a delivered word.
  a_padded_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (padded_length[3:0] == 4'b0000))
    else $error("padded length not a multiple of sixteen");

  // The length word carries the padded length derived from itself and never ends a frame.
  a_length_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_position == POS_W'(0))) |->
      ((padded_length == ((POS_W'(frame_byte) + POS_W'(20)) & ~POS_W'(15)))
       && !end_of_frame))
    else $error("length word inconsistent with its padded length");

  // End of frame only ever marks a payload word.
  a_eof_in_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> (frame_position >= POS_W'(2)))
    else $error("end of frame outside the payload");

endmodule
